[rtl/core/gdse_pkg.sv]
// Shared types, codes and the GCR table of the disk sector encoder.
// Holds the job record passed from the front end through the job queue to the back end.
// No dependencies.
package gdse_pkg;

   localparam int BYTE_W   = 8;
   localparam int TRACK_W  = 6;
   localparam int SECTOR_W = 5;
   localparam int GAP_W    = 5;
   localparam int CHUNK_W  = 10;
   localparam int LENGTH_W = 4;

   // Injected error codes; any other value has no effect.
   localparam logic [BYTE_W-1:0] ERR_NONE        = 8'd0;
   localparam logic [BYTE_W-1:0] ERR_HEADER_MARK = 8'd2;
   localparam logic [BYTE_W-1:0] ERR_NO_SYNC     = 8'd3;
   localparam logic [BYTE_W-1:0] ERR_DATA_MARK   = 8'd4;
   localparam logic [BYTE_W-1:0] ERR_DATA_SUM    = 8'd5;
   localparam logic [BYTE_W-1:0] ERR_HEADER_SUM  = 8'd9;
   localparam logic [BYTE_W-1:0] ERR_DISK_ID     = 8'd11;

   // Register indexes on the csr_ port.
   localparam logic REG_DISK_ID_FIRST  = 1'b0;
   localparam logic REG_DISK_ID_SECOND = 1'b1;

   // One accepted data byte with everything the back end needs to emit its chunks.
   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic                first;
      logic                last;
      logic [BYTE_W-1:0]   sync_byte;
      logic [BYTE_W-1:0]   header_mark;
      logic [BYTE_W-1:0]   header_sum;
      logic [SECTOR_W-1:0] sector;
      logic [BYTE_W-1:0]   track_next;
      logic [BYTE_W-1:0]   id_second;
      logic [BYTE_W-1:0]   id_first;
      logic [BYTE_W-1:0]   data_mark;
      logic [BYTE_W-1:0]   data_sum;
      logic [GAP_W-1:0]    tail_gap;
   } job_type;

   // Standard 4-to-5 GCR nibble code.
   function automatic logic [4:0] gcr_nibble(input logic [3:0] nib);
      logic [4:0] code;
      case (nib)
         4'h0: code = 5'h0A;
         4'h1: code = 5'h0B;
         4'h2: code = 5'h12;
         4'h3: code = 5'h13;
         4'h4: code = 5'h0E;
         4'h5: code = 5'h0F;
         4'h6: code = 5'h16;
         4'h7: code = 5'h17;
         4'h8: code = 5'h09;
         4'h9: code = 5'h19;
         4'hA: code = 5'h1A;
         4'hB: code = 5'h1B;
         4'hC: code = 5'h0D;
         4'hD: code = 5'h1D;
         4'hE: code = 5'h1E;
         4'hF: code = 5'h15;
         default: code = 5'h0A;
      endcase
      return code;
   endfunction

   // Byte to 10-bit GCR code, high nibble first.
   function automatic logic [CHUNK_W-1:0] gcr_code(input logic [BYTE_W-1:0] b);
      return {gcr_nibble(b[7:4]), gcr_nibble(b[3:0])};
   endfunction

endpackage

[rtl/core/gdse_front.sv]
// Front end of the disk sector encoder: tracks sector position and checksum, builds jobs.
// Depends on gdse_pkg.
module gdse_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [gdse_pkg::BYTE_W-1:0]     data_byte,
   input  logic [gdse_pkg::TRACK_W-1:0]    track_index,
   input  logic [gdse_pkg::SECTOR_W-1:0]   sector_number,
   input  logic [gdse_pkg::BYTE_W-1:0]     error_code,
   input  logic [gdse_pkg::BYTE_W-1:0]     disk_id_first,
   input  logic [gdse_pkg::BYTE_W-1:0]     disk_id_second,
   output gdse_pkg::job_type               job
);

   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] HEADER_MARK = 8'h08;
   localparam logic [7:0] DATA_MARK   = 8'h07;
   localparam logic [7:0] LAST_POS    = 8'hFF;

   logic [7:0]                       pos_ff, pos_in;
   logic [7:0]                       sum_ff, sum_in;
   logic [gdse_pkg::TRACK_W-1:0]     track_ff, track_in;
   logic [7:0]                       err_ff, err_in;

   logic                             first;
   logic [gdse_pkg::TRACK_W-1:0]     trk;
   logic [7:0]                       err;
   logic [7:0]                       trk_next;
   logic [7:0]                       hsum;
   logic [7:0]                       sum_new;
   logic [gdse_pkg::GAP_W-1:0]       gap;

   always_comb begin
      first    = (pos_ff == 8'd0);
      trk      = first ? track_index : track_ff;
      err      = first ? error_code : err_ff;
      trk_next = 8'({2'b00, track_index} + 8'd1);
      hsum     = disk_id_first ^ disk_id_second ^ trk_next ^ {3'b000, sector_number};
      sum_new  = (first ? 8'd0 : sum_ff) ^ data_byte;

      // Tail gap by speed zone; out-of-range tracks fall in the innermost zone.
      if (trk < 6'd17) begin
         gap = 5'd8;
      end else if (trk < 6'd24) begin
         gap = 5'd17;
      end else if (trk < 6'd30) begin
         gap = 5'd12;
      end else begin
         gap = 5'd9;
      end

      job.data_byte   = data_byte;
      job.first       = first;
      job.last        = (pos_ff == LAST_POS);
      job.sync_byte   = (err == gdse_pkg::ERR_NO_SYNC) ? 8'h00 : SYNC_BYTE;
      job.header_mark = (err == gdse_pkg::ERR_HEADER_MARK) ? 8'h00 : HEADER_MARK;
      job.header_sum  = (err == gdse_pkg::ERR_HEADER_SUM) ? ~hsum : hsum;
      job.sector      = sector_number;
      job.track_next  = trk_next;
      job.id_second   = (err == gdse_pkg::ERR_DISK_ID) ? ~disk_id_second : disk_id_second;
      job.id_first    = (err == gdse_pkg::ERR_DISK_ID) ? ~disk_id_first : disk_id_first;
      job.data_mark   = (err == gdse_pkg::ERR_DATA_MARK) ? 8'h00 : DATA_MARK;
      job.data_sum    = (err == gdse_pkg::ERR_DATA_SUM) ? ~sum_new : sum_new;
      job.tail_gap    = gap;

      pos_in   = pos_ff;
      sum_in   = sum_ff;
      track_in = track_ff;
      err_in   = err_ff;
      if (accept) begin
         pos_in   = 8'(pos_ff + 8'd1);
         sum_in   = sum_new;
         track_in = trk;
         err_in   = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         track_ff <= '0;
         err_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         track_ff <= track_in;
         err_ff   <= err_in;
      end
   end

endmodule

[rtl/core/gdse_queue.sv]
// Short job queue between the front end and the back end of the sector encoder.
// Depends on gdse_pkg.
module gdse_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gdse_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output gdse_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   gdse_pkg::job_type slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/gdse_back.sv]
// Back end of the sector encoder: steps through the chunks of each job into an output register.
// Depends on gdse_pkg.
module gdse_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  gdse_pkg::job_type                   job,
   output logic                                job_done,
   input  logic                                out_pop,
   output logic                                out_empty,
   output logic [gdse_pkg::CHUNK_W-1:0]        out_bits,
   output logic [gdse_pkg::LENGTH_W-1:0]       out_length,
   output logic                                out_last
);

   localparam int STEP_W = 6;

   localparam logic [STEP_W-1:0] STEP_SYNC_A      = 6'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC_A_END  = 6'd4;
   localparam logic [STEP_W-1:0] STEP_HEADER_MARK = 6'd5;
   localparam logic [STEP_W-1:0] STEP_HEADER_SUM  = 6'd6;
   localparam logic [STEP_W-1:0] STEP_SECTOR      = 6'd7;
   localparam logic [STEP_W-1:0] STEP_TRACK       = 6'd8;
   localparam logic [STEP_W-1:0] STEP_ID_SECOND   = 6'd9;
   localparam logic [STEP_W-1:0] STEP_ID_FIRST    = 6'd10;
   localparam logic [STEP_W-1:0] STEP_PAD         = 6'd11;
   localparam logic [STEP_W-1:0] STEP_PAD_END     = 6'd12;
   localparam logic [STEP_W-1:0] STEP_GAP         = 6'd13;
   localparam logic [STEP_W-1:0] STEP_GAP_END     = 6'd21;
   localparam logic [STEP_W-1:0] STEP_SYNC_B      = 6'd22;
   localparam logic [STEP_W-1:0] STEP_SYNC_B_END  = 6'd26;
   localparam logic [STEP_W-1:0] STEP_DATA_MARK   = 6'd27;
   localparam logic [STEP_W-1:0] STEP_DATA        = 6'd28;
   localparam logic [STEP_W-1:0] STEP_DATA_SUM    = 6'd29;
   localparam logic [STEP_W-1:0] STEP_ZERO        = 6'd30;
   localparam logic [STEP_W-1:0] STEP_ZERO_END    = 6'd31;
   localparam logic [STEP_W-1:0] STEP_TAIL        = 6'd32;

   localparam logic [7:0] PAD_BYTE  = 8'h0F;
   localparam logic [7:0] FILL_BYTE = 8'h55;
   localparam logic [gdse_pkg::LENGTH_W-1:0] LEN_RAW = 4'd8;
   localparam logic [gdse_pkg::LENGTH_W-1:0] LEN_GCR = 4'd10;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              started_ff, started_in;
   logic              valid_ff, valid_in;
   logic [gdse_pkg::CHUNK_W-1:0]  bits_ff, bits_in;
   logic [gdse_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic              last_ff, last_in;

   logic [STEP_W-1:0] cur_step;
   logic [STEP_W-1:0] end_step;
   logic              advance;
   logic              at_end;
   logic              sel_raw;
   logic [7:0]        sel_byte;

   assign out_empty  = !valid_ff;
   assign out_bits   = bits_ff;
   assign out_length = len_ff;
   assign out_last   = last_ff;

   always_comb begin
      if (started_ff) begin
         cur_step = step_ff;
      end else begin
         cur_step = job.first ? STEP_SYNC_A : STEP_DATA;
      end
      end_step = job.last ? STEP_W'(STEP_TAIL + {1'b0, job.tail_gap} - 6'd1) : STEP_DATA;
      at_end   = (cur_step == end_step);
      advance  = job_valid && (!valid_ff || out_pop);
      job_done = advance && at_end;

      sel_raw  = 1'b0;
      sel_byte = FILL_BYTE;
      case (cur_step) inside
         [STEP_SYNC_A:STEP_SYNC_A_END],
         [STEP_SYNC_B:STEP_SYNC_B_END]: begin
            sel_raw  = 1'b1;
            sel_byte = job.sync_byte;
         end
         STEP_HEADER_MARK: sel_byte = job.header_mark;
         STEP_HEADER_SUM:  sel_byte = job.header_sum;
         STEP_SECTOR:      sel_byte = {3'b000, job.sector};
         STEP_TRACK:       sel_byte = job.track_next;
         STEP_ID_SECOND:   sel_byte = job.id_second;
         STEP_ID_FIRST:    sel_byte = job.id_first;
         [STEP_PAD:STEP_PAD_END]: sel_byte = PAD_BYTE;
         [STEP_GAP:STEP_GAP_END]: begin
            sel_raw  = 1'b1;
            sel_byte = FILL_BYTE;
         end
         STEP_DATA_MARK:   sel_byte = job.data_mark;
         STEP_DATA:        sel_byte = job.data_byte;
         STEP_DATA_SUM:    sel_byte = job.data_sum;
         [STEP_ZERO:STEP_ZERO_END]: sel_byte = 8'h00;
         default: begin
            sel_raw  = 1'b1;
            sel_byte = FILL_BYTE;
         end
      endcase

      step_in    = step_ff;
      started_in = started_ff;
      valid_in   = valid_ff;
      bits_in    = bits_ff;
      len_in     = len_ff;
      last_in    = last_ff;
      if (advance) begin
         valid_in   = 1'b1;
         bits_in    = sel_raw ? {2'b00, sel_byte} : gdse_pkg::gcr_code(sel_byte);
         len_in     = sel_raw ? LEN_RAW : LEN_GCR;
         last_in    = at_end;
         started_in = !at_end;
         step_in    = STEP_W'(cur_step + 6'd1);
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      len_ff  <= len_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

endmodule

[rtl/core/gcr_disk_sector_encoder.sv]
// Top level of the GCR disk sector encoder: register port, front end, job queue, back end.
// Depends on gdse_pkg, gdse_front, gdse_queue and gdse_back.
//
// Usage: push the 256 data bytes of a sector in order on the req_ queue port. The first
// byte of a sector also carries the track index, sector number and error code; the track
// index and error code are held for the whole sector. Each byte is one transaction; the
// chunks it causes come out of the rsp_ queue port in order, one transaction per chunk,
// and the final chunk of a byte is flagged with rsp_last_of_run.
// - The first byte yields 29 chunks (sync, header, gap, sync, data mark, data code).
// - Middle bytes yield one GCR chunk each.
// - The last byte yields 4 chunks plus a tail gap of 8 to 17 raw bytes by speed zone.
// With the output register free, an accepted transaction is first written into the job
// queue, then its first chunk is registered into the output register on the rsp_ ports.
// Throughput: unstalled, the back end emits one chunk per cycle, so middle bytes stream
// at one per cycle; the chunk sequencer is the bottleneck during header and tail bursts,
// while the job queue keeps accepting until it fills. When rsp_pop stays low the output
// register holds its chunk, the sequencer stalls, the queue fills and req_full rises.
// Reset clears the sector position, checksum, held fields, disk ids, queue and output.
// Write csr_ registers only while the block is idle.
module gcr_disk_sector_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input queue port
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [gdse_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic [gdse_pkg::TRACK_W-1:0]        req_track_index,
   input  logic [gdse_pkg::SECTOR_W-1:0]       req_sector_number,
   input  logic [gdse_pkg::BYTE_W-1:0]         req_error_code,
   // Result queue port
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [gdse_pkg::CHUNK_W-1:0]        rsp_chunk_bits,
   output logic [gdse_pkg::LENGTH_W-1:0]       rsp_chunk_length,
   output logic                                rsp_last_of_run,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [7:0] id_first_ff, id_first_in;
   logic [7:0] id_second_ff, id_second_in;
   logic       csr_write;
   logic       reg_sel;

   logic              req_accept;
   logic              queue_empty;
   logic              job_done;
   gdse_pkg::job_type front_job;
   gdse_pkg::job_type head_job;

   // Registers sit at word addresses; address bit 2 picks the register.
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      id_first_in  = id_first_ff;
      id_second_in = id_second_ff;
      if (csr_write) begin
         case (reg_sel)
            gdse_pkg::REG_DISK_ID_FIRST:  id_first_in  = csr_pwdata[7:0];
            gdse_pkg::REG_DISK_ID_SECOND: id_second_in = csr_pwdata[7:0];
            default: id_first_in = id_first_ff;
         endcase
      end
      case (reg_sel)
         gdse_pkg::REG_DISK_ID_FIRST:  csr_prdata = {24'd0, id_first_ff};
         gdse_pkg::REG_DISK_ID_SECOND: csr_prdata = {24'd0, id_second_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_first_ff  <= '0;
         id_second_ff <= '0;
      end else begin
         id_first_ff  <= id_first_in;
         id_second_ff <= id_second_in;
      end
   end

   // Take a byte whenever the job queue has room.
   assign req_accept = req_push && !req_full;

   gdse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .track_index    (req_track_index),
      .sector_number  (req_sector_number),
      .error_code     (req_error_code),
      .disk_id_first  (id_first_ff),
      .disk_id_second (id_second_ff),
      .job            (front_job)
   );

   gdse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_job (front_job),
      .pop      (job_done),
      .full     (req_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // Drain jobs one chunk per cycle into the output register while it is free or popped.
   gdse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (!queue_empty),
      .job        (head_job),
      .job_done   (job_done),
      .out_pop    (rsp_pop),
      .out_empty  (rsp_empty),
      .out_bits   (rsp_chunk_bits),
      .out_length (rsp_chunk_length),
      .out_last   (rsp_last_of_run)
   );

endmodule
